// ===== hdl/fmqc_pkg.sv =====
// ----------------------------------------------------------------------------
// fmqc_pkg
// Shared types, constants and tables for the mains quality classifier.
// ----------------------------------------------------------------------------
package fmqc_pkg;

   localparam int unsigned MaxDisturbDefault = 120;
   localparam int unsigned QDepth            = 2;

   // Request kinds
   typedef enum logic [1:0] {
      REQ_EVAL   = 2'd0,
      REQ_TICK   = 2'd1,
      REQ_BUTTON = 2'd2,
      REQ_UNUSED = 2'd3
   } req_kind_type;

   // Result categories
   typedef enum logic [2:0] {
      CAT_OVER    = 3'd0,
      CAT_SWELL   = 3'd1,
      CAT_NORMAL  = 3'd2,
      CAT_UNDER   = 3'd3,
      CAT_SAG     = 3'd4,
      CAT_STANDBY = 3'd5,
      CAT_DANGER  = 3'd6
   } category_type;

   // Back-end sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MEMB,
      ST_RULE,
      ST_SETUP,
      ST_DIV,
      ST_DONE
   } back_state_type;

   // One evaluation job handed from front to back
   typedef struct packed {
      logic       ovr;
      logic [11:0] volt;
      logic [7:0]  curr;
      logic [6:0]  secs;
   } job_type;

   localparam logic [17:0] QualOne      = 18'd65536;
   localparam logic [17:0] QualHalf     = 18'd32768;
   localparam logic [17:0] QualOverride = 18'd131072;

   // Rule tables: voltage set, current set, time set, output in tenths
   localparam logic [1:0] RuleV [12] = '{2'd0, 2'd0, 2'd0, 2'd0, 2'd2, 2'd2,
                                         2'd2, 2'd2, 2'd1, 2'd1, 2'd1, 2'd1};
   localparam logic       RuleI [12] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1,
                                         1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1};
   localparam logic       RuleT [12] = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1,
                                         1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1};
   localparam logic [3:0] RuleZ [12] = '{4'd4, 4'd4, 4'd2, 4'd2, 4'd10, 4'd10,
                                         4'd8, 4'd8, 4'd0, 4'd6, 4'd6, 4'd6};

   // Map a Q16 quality value to its category; thresholds compare 10*q
   function automatic category_type category_of(input logic [17:0] q);
      logic [20:0] t;
      category_type c;
      t = {q, 3'b000} + {2'b00, q, 1'b0};
      if (t >= 21'd589824 && t < 21'd1245184) begin
         c = CAT_OVER;
      end else if (t >= 21'd458752 && t < 21'd589824) begin
         c = CAT_SWELL;
      end else if (t >= 21'd327680 && t < 21'd458752) begin
         c = CAT_NORMAL;
      end else if (t >= 21'd196608 && t < 21'd327680) begin
         c = CAT_UNDER;
      end else if (t >= 21'd65536 && t < 21'd196608) begin
         c = CAT_SAG;
      end else if (t < 21'd65536) begin
         c = CAT_STANDBY;
      end else begin
         c = CAT_DANGER;
      end
      return c;
   endfunction

endpackage

// ===== hdl/fmqc_front.sv =====
// ----------------------------------------------------------------------------
// fmqc_front
// Accepts requests, runs the safety check and input clamps, and keeps the
// disturbance counter. Evaluations are pushed to the job queue.
// ----------------------------------------------------------------------------
module fmqc_front
   import fmqc_pkg::*;
#(
   parameter int unsigned MAX_DISTURB_SECONDS = MaxDisturbDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        queue_full,
   input  logic [1:0]  req_type,
   input  logic [15:0] req_voltage_dv,
   input  logic [16:0] req_current_ma,
   output logic        push,
   output job_type     push_job
);

   localparam logic [6:0] SecsCap =
      7'((MAX_DISTURB_SECONDS > 127) ? 127 : MAX_DISTURB_SECONDS);

   logic [6:0] disturb_seconds_ff, disturb_seconds_in;
   logic       disturb_running_ff, disturb_running_in;
   logic       accept;
   logic       ovr;
   logic [11:0] volt;
   logic [7:0]  curr;
   logic [6:0]  secs;
   logic        disturbed;

   assign accept = req_valid && !queue_full;

   // Safety check and clamps
   always_comb begin
      ovr  = (req_voltage_dv > 16'd2500) ||
             (req_voltage_dv < 16'd1000 && req_voltage_dv != 16'd0);
      volt = (req_voltage_dv < 16'd1000) ? 12'd1000 : req_voltage_dv[11:0];
      curr = (req_current_ma > 17'd200) ? 8'd200 : req_current_ma[7:0];
      secs = (disturb_seconds_ff > 7'd120) ? 7'd120 : disturb_seconds_ff;
      disturbed = (volt <= 12'd1980) || (volt >= 12'd2420) || (curr <= 8'd70);
   end

   // Counter update and job push
   always_comb begin
      disturb_seconds_in = disturb_seconds_ff;
      disturb_running_in = disturb_running_ff;
      push               = 1'b0;
      push_job.ovr       = ovr;
      push_job.volt      = volt;
      push_job.curr      = curr;
      push_job.secs      = ovr ? 7'd0 : secs;
      if (accept) begin
         unique case (req_kind_type'(req_type))
            REQ_EVAL: begin
               push = 1'b1;
               if (!ovr) begin
                  if (disturbed) begin
                     disturb_running_in = 1'b1;
                  end else begin
                     disturb_running_in = 1'b0;
                     disturb_seconds_in = 7'd0;
                  end
               end
            end
            REQ_TICK: begin
               if (disturb_running_ff && disturb_seconds_ff < SecsCap) begin
                  disturb_seconds_in = disturb_seconds_ff + 7'd1;
               end
            end
            REQ_BUTTON: begin
               disturb_running_in = 1'b0;
               disturb_seconds_in = 7'd0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         disturb_seconds_ff <= 7'd0;
         disturb_running_ff <= 1'b0;
      end else begin
         disturb_seconds_ff <= disturb_seconds_in;
         disturb_running_ff <= disturb_running_in;
      end
   end

endmodule

// ===== hdl/fmqc_queue.sv =====
// ----------------------------------------------------------------------------
// fmqc_queue
// Short job queue between the front and the back end.
// ----------------------------------------------------------------------------
module fmqc_queue
   import fmqc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   input  logic    pop,
   output logic    full,
   output logic    not_empty,
   output job_type head_job
);

   localparam int unsigned PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
   localparam int unsigned CntW = $clog2(QDepth + 1);

   job_type            entry_ff [QDepth];
   logic [PtrW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]    count_ff, count_in;

   assign full      = (count_ff == CntW'(QDepth));
   assign not_empty = (count_ff != '0);
   assign head_job  = entry_ff[rd_ptr_ff];

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(QDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(QDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store pushed job
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(QDepth))
      else $error("queue count above depth");
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!full || pop))
      else $error("push into full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("pop from empty queue");
`endif

endmodule

// ===== hdl/fmqc_back.sv =====
// ----------------------------------------------------------------------------
// fmqc_back
// Runs one job: memberships one per cycle, rules one per cycle, a serial
// restoring divide for the weighted average, then the category map.
// ----------------------------------------------------------------------------
module fmqc_back
   import fmqc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        job_ready,
   input  job_type     job,
   output logic        pop,
   input  logic        rsp_stall,
   output logic        rsp_valid,
   output logic [17:0] rsp_quality_level,
   output logic [2:0]  rsp_category,
   output logic        rsp_relay_closed,
   output logic        rsp_red_led,
   output logic        rsp_blue_led,
   output logic        rsp_override_hit,
   output logic [6:0]  rsp_seconds_used
);

   // Reciprocals ceil(2^32 / den) for the membership slopes
   localparam logic [63:0] Recip10w  = ((64'd1 << 32) + 64'd9) / 64'd10;
   localparam logic [63:0] Recip20w  = ((64'd1 << 32) + 64'd19) / 64'd20;
   localparam logic [63:0] Recip30w  = ((64'd1 << 32) + 64'd29) / 64'd30;
   localparam logic [63:0] Recip220w = ((64'd1 << 32) + 64'd219) / 64'd220;
   localparam logic [28:0] Recip10   = Recip10w[28:0];
   localparam logic [28:0] Recip20   = Recip20w[28:0];
   localparam logic [28:0] Recip30   = Recip30w[28:0];
   localparam logic [28:0] Recip220  = Recip220w[28:0];

   back_state_type state_ff, state_in;
   job_type        job_ff, job_in;
   logic [3:0]     step_ff, step_in;
   logic [4:0]     iter_ff, iter_in;
   logic [16:0]    mv_ff [3];
   logic [16:0]    mi_ff [2];
   logic [16:0]    mt_ff [2];
   logic [19:0]    sw_ff, sw_in;
   logic [22:0]    swz_ff, swz_in;
   logic [23:0]    rem_ff, rem_in;
   logic [22:0]    den_ff, den_in;
   logic [16:0]    quot_ff, quot_in;

   logic           rsp_valid_ff, rsp_valid_in;
   logic [17:0]    qual_ff;
   category_type   cat_ff;
   logic           relay_ff, blue_ff, ovr_ff;
   logic [6:0]     secs_ff;

   logic           memb_full, memb_zero;
   logic [7:0]     memb_n;
   logic [28:0]    memb_recip;
   logic [36:0]    memb_prod;
   logic [16:0]    memb_val;
   logic           memb_we;
   logic [16:0]    w;
   logic [20:0]    wz;
   logic           ge;
   logic [23:0]    diff;
   logic           out_load;
   logic [17:0]    out_qual;
   category_type   out_cat;

   // Membership term for the current step: one slope through a reciprocal
   always_comb begin
      memb_full  = 1'b0;
      memb_zero  = 1'b0;
      memb_n     = 8'd0;
      memb_recip = Recip20;
      unique case (step_ff[2:0])
         3'd0: begin
            memb_full = job_ff.volt <= 12'd1980;
            memb_zero = job_ff.volt > 12'd2000;
            memb_n    = 8'(12'd2000 - job_ff.volt);
         end
         3'd1: begin
            memb_zero  = (job_ff.volt <= 12'd1980) || (job_ff.volt >= 12'd2420);
            memb_n     = (job_ff.volt <= 12'd2200) ? 8'(job_ff.volt - 12'd1980)
                                                   : 8'(12'd2420 - job_ff.volt);
            memb_recip = Recip220;
         end
         3'd2: begin
            memb_full = job_ff.volt >= 12'd2420;
            memb_zero = job_ff.volt < 12'd2400;
            memb_n    = 8'(job_ff.volt - 12'd2400);
         end
         3'd3: begin
            memb_full  = job_ff.curr <= 8'd70;
            memb_zero  = job_ff.curr > 8'd100;
            memb_n     = 8'd100 - job_ff.curr;
            memb_recip = Recip30;
         end
         3'd4: begin
            memb_full  = job_ff.curr >= 8'd100;
            memb_zero  = job_ff.curr < 8'd70;
            memb_n     = job_ff.curr - 8'd70;
            memb_recip = Recip30;
         end
         3'd5: begin
            memb_full = job_ff.secs <= 7'd40;
            memb_zero = job_ff.secs > 7'd60;
            memb_n    = 8'(7'd60 - job_ff.secs);
         end
         3'd6: begin
            memb_full  = job_ff.secs >= 7'd60;
            memb_zero  = job_ff.secs < 7'd50;
            memb_n     = 8'(job_ff.secs - 7'd50);
            memb_recip = Recip10;
         end
         default: begin
         end
      endcase
      memb_prod = 37'(memb_n) * 37'(memb_recip);
      if (memb_full) begin
         memb_val = 17'h10000;
      end else if (memb_zero) begin
         memb_val = 17'd0;
      end else begin
         memb_val = memb_prod[32:16];
      end
   end

   // Rule weight for the current step: min of three memberships
   always_comb begin
      logic [16:0] a, b, c, m;
      a  = mv_ff[RuleV[step_ff]];
      b  = mi_ff[RuleI[step_ff]];
      c  = mt_ff[RuleT[step_ff]];
      m  = (a < b) ? a : b;
      w  = (m < c) ? m : c;
      wz = 21'(w) * 21'(RuleZ[step_ff]);
   end

   // One restoring divide step
   always_comb begin
      ge   = rem_ff >= {1'b0, den_ff};
      diff = ge ? rem_ff - {1'b0, den_ff} : rem_ff;
   end

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      step_in      = step_ff;
      iter_in      = iter_ff;
      sw_in        = sw_ff;
      swz_in       = swz_ff;
      rem_in       = rem_ff;
      den_in       = den_ff;
      quot_in      = quot_ff;
      pop          = 1'b0;
      memb_we      = 1'b0;
      out_load     = 1'b0;
      out_qual     = QualHalf;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_IDLE: begin
            if (job_ready && !rsp_valid_ff) begin
               pop    = 1'b1;
               job_in = job;
               if (job.ovr) begin
                  out_load = 1'b1;
                  out_qual = QualOverride;
               end else begin
                  state_in = ST_MEMB;
                  step_in  = 4'd0;
               end
            end
         end
         ST_MEMB: begin
            memb_we = 1'b1;
            if (step_ff == 4'd6) begin
               state_in = ST_RULE;
               step_in  = 4'd0;
               sw_in    = 20'd0;
               swz_in   = 23'd0;
            end else begin
               step_in = step_ff + 4'd1;
            end
         end
         ST_RULE: begin
            sw_in  = sw_ff + 20'(w);
            swz_in = swz_ff + 23'(wz);
            if (step_ff == 4'd11) begin
               state_in = ST_SETUP;
            end else begin
               step_in = step_ff + 4'd1;
            end
         end
         ST_SETUP: begin
            rem_in  = {1'b0, swz_ff};
            den_in  = 23'({sw_ff, 3'b000} + {3'b000, sw_ff, 1'b0});
            quot_in = 17'd0;
            iter_in = 5'd0;
            state_in = (sw_ff == 20'd0) ? ST_DONE : ST_DIV;
         end
         ST_DIV: begin
            rem_in  = {diff[22:0], 1'b0};
            quot_in = {quot_ff[15:0], ge};
            iter_in = iter_ff + 5'd1;
            if (iter_ff == 5'd16) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            out_load = 1'b1;
            if (sw_ff == 20'd0) begin
               out_qual = QualHalf;
            end else if (18'(quot_ff) > QualOne) begin
               out_qual = QualOne;
            end else begin
               out_qual = 18'(quot_ff);
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   assign out_cat = category_of(out_qual);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      job_ff  <= job_in;
      step_ff <= step_in;
      iter_ff <= iter_in;
      sw_ff   <= sw_in;
      swz_ff  <= swz_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
      if (memb_we) begin
         unique case (step_ff[2:0])
            3'd0:    mv_ff[0] <= memb_val;
            3'd1:    mv_ff[1] <= memb_val;
            3'd2:    mv_ff[2] <= memb_val;
            3'd3:    mi_ff[0] <= memb_val;
            3'd4:    mi_ff[1] <= memb_val;
            3'd5:    mt_ff[0] <= memb_val;
            default: mt_ff[1] <= memb_val;
         endcase
      end
   end

   // Output register: load result fields
   always_ff @(posedge clock) begin
      if (out_load) begin
         qual_ff  <= out_qual;
         cat_ff   <= out_cat;
         relay_ff <= !(out_cat == CAT_OVER || out_cat == CAT_UNDER ||
                       out_cat == CAT_STANDBY || out_cat == CAT_DANGER);
         blue_ff  <= (out_cat == CAT_SWELL || out_cat == CAT_SAG);
         ovr_ff   <= job_in.ovr;
         secs_ff  <= job_in.ovr ? 7'd0 : job_in.secs;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_quality_level = qual_ff;
   assign rsp_category      = cat_ff;
   assign rsp_relay_closed  = relay_ff;
   assign rsp_red_led       = !relay_ff;
   assign rsp_blue_led      = blue_ff;
   assign rsp_override_hit  = ovr_ff;
   assign rsp_seconds_used  = secs_ff;

`ifndef SYNTHESIS
   a_ovr_danger: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && ovr_ff) |-> (cat_ff == CAT_DANGER && secs_ff == 7'd0))
      else $error("override result not dangerous");
   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (den_ff != 23'd0))
      else $error("divide with zero weight sum");
   a_qual_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !ovr_ff) |-> (qual_ff <= QualOne))
      else $error("quality level above one");
`endif

endmodule

// ===== hdl/fuzzy_mains_quality_classifier_top.sv =====
// ----------------------------------------------------------------------------
// fuzzy_mains_quality_classifier_top
// Mains quality classifier with zero-order Sugeno fuzzy inference.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid / req_stall): req_type selects evaluate,
//   one-second tick or button clear. Ticks and button clears update the
//   disturbance counter at once and give no result. An evaluate request gives
//   exactly one result transfer on the rsp_ channel.
//   Sequence: an override evaluation passes the job queue and its result is
//   loaded as soon as the back end pops it; a normal one runs the back-end
//   sequencer through job pop, the membership terms, the rule weights,
//   setup, the serial restoring divide and result load. One evaluation is in
//   the back end at a time and a new job is taken only once the previous
//   result has left; a two-entry job queue lets the front take further
//   requests meanwhile.
//   req_stall rises when the job queue is full. When rsp_stall is high the
//   result holds in the output register and the back end takes no new job.
//   Synchronous reset clears the counter, the queue and the output valid.
// ----------------------------------------------------------------------------
module fuzzy_mains_quality_classifier_top
   import fmqc_pkg::*;
#(
   parameter int unsigned MAX_DISTURB_SECONDS = MaxDisturbDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_type,
   input  logic [15:0] req_voltage_dv,
   input  logic [16:0] req_current_ma,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [17:0] rsp_quality_level,
   output logic [2:0]  rsp_category,
   output logic        rsp_relay_closed,
   output logic        rsp_red_led,
   output logic        rsp_blue_led,
   output logic        rsp_override_hit,
   output logic [6:0]  rsp_seconds_used
);

   logic    q_full, q_not_empty, q_push, q_pop;
   job_type push_job, head_job;

   assign req_stall = q_full;

   fmqc_front #(
      .MAX_DISTURB_SECONDS(MAX_DISTURB_SECONDS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .queue_full    (q_full),
      .req_type      (req_type),
      .req_voltage_dv(req_voltage_dv),
      .req_current_ma(req_current_ma),
      .push          (q_push),
      .push_job      (push_job)
   );

   fmqc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .pop      (q_pop),
      .full     (q_full),
      .not_empty(q_not_empty),
      .head_job (head_job)
   );

   fmqc_back u_back (
      .clock            (clock),
      .reset            (reset),
      .job_ready        (q_not_empty),
      .job              (head_job),
      .pop              (q_pop),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_quality_level(rsp_quality_level),
      .rsp_category     (rsp_category),
      .rsp_relay_closed (rsp_relay_closed),
      .rsp_red_led      (rsp_red_led),
      .rsp_blue_led     (rsp_blue_led),
      .rsp_override_hit (rsp_override_hit),
      .rsp_seconds_used (rsp_seconds_used)
   );

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives evaluate, tick and button requests into the mains quality classifier
// and checks every result against a bit-exact fixed-point predictor.
// ----------------------------------------------------------------------------
module tb_top;
   import fmqc_pkg::*;

   typedef struct {
      logic [1:0]  kind;
      logic [15:0] volt;
      logic [16:0] curr;
   } sample_t;

   typedef struct {
      logic [17:0] level;
      logic [2:0]  cat;
      logic        relay;
      logic        red;
      logic        blue;
      logic        ovr;
      logic [6:0]  secs;
   } verdict_t;

   localparam int unsigned CycleLimit = 400000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_type = REQ_EVAL;
   logic [15:0] req_voltage_dv = '0;
   logic [16:0] req_current_ma = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [17:0] rsp_quality_level;
   logic [2:0]  rsp_category;
   logic        rsp_relay_closed;
   logic        rsp_red_led;
   logic        rsp_blue_led;
   logic        rsp_override_hit;
   logic [6:0]  rsp_seconds_used;

   sample_t  pending_q[$];
   verdict_t verdict_q[$];
   int       idle_pct = 0;
   int       stall_pct = 0;
   int       fails = 0;
   int       cycles = 0;
   int       sent = 0;
   int       total = 0;

   // predictor state
   logic [6:0] dist_secs = '0;
   logic       dist_run = 1'b0;

   fuzzy_mains_quality_classifier_top u_dut (.*);

   function automatic logic [31:0] frac_q16(input int unsigned num, input int unsigned den);
      return 32'((longint'(num) << 16) / den);
   endfunction

   function automatic logic [31:0] trap(input int unsigned x, a, b, c, d);
      int unsigned t1, t2;
      if (x <= c) t1 = 65536;
      else if (x > d) t1 = 0;
      else t1 = frac_q16(d - x, d - c);
      if (x >= b) t2 = 65536;
      else if (x < a) t2 = 0;
      else t2 = frac_q16(x - a, b - a);
      return t1 < t2 ? t1 : t2;
   endfunction

   function automatic logic [31:0] tri_m(input int unsigned x, a, b, c);
      if (x <= a || x >= c) return 0;
      if (x <= b) return frac_q16(x - a, b - a);
      return frac_q16(c - x, c - b);
   endfunction

   function automatic category_type classify(input int unsigned q);
      longint t;
      t = longint'(q) * 10;
      if (t >= 9 * 65536 && t < 19 * 65536) return CAT_OVER;
      if (t >= 7 * 65536) return t < 9 * 65536 ? CAT_SWELL : CAT_DANGER;
      if (t >= 5 * 65536) return CAT_NORMAL;
      if (t >= 3 * 65536) return CAT_UNDER;
      if (t >= 65536) return CAT_SAG;
      return CAT_STANDBY;
   endfunction

   // Apply one accepted request to the predictor; queue a verdict for evaluations
   task automatic predict_sample(input sample_t s);
      int unsigned v, c, secs, q, w, cap;
      int unsigned mv[3], mi[2], mt[2];
      longint sw, swz;
      int zt[12], rv[12], ri[12], rt[12];
      category_type cat;
      verdict_t e;
      zt = '{4, 4, 2, 2, 10, 10, 8, 8, 0, 6, 6, 6};
      rv = '{0, 0, 0, 0, 2, 2, 2, 2, 1, 1, 1, 1};
      ri = '{0, 1, 0, 1, 0, 1, 0, 1, 0, 0, 1, 1};
      rt = '{1, 1, 0, 0, 1, 1, 0, 0, 1, 0, 0, 1};
      secs = 0;
      cap = MaxDisturbDefault > 127 ? 127 : MaxDisturbDefault;
      if (s.kind == REQ_TICK) begin
         if (dist_run && dist_secs < cap) dist_secs = dist_secs + 7'd1;
         return;
      end
      if (s.kind == REQ_BUTTON) begin
         dist_secs = '0;
         dist_run = 1'b0;
         return;
      end
      if (s.kind != REQ_EVAL) return;
      e.ovr = 1'b0;
      if (s.volt > 2500 || (s.volt < 1000 && s.volt > 0)) begin
         q = 131072;
         e.ovr = 1'b1;
      end else begin
         v = s.volt < 1000 ? 1000 : s.volt;
         c = s.curr > 200 ? 200 : s.curr;
         secs = dist_secs > 120 ? 120 : dist_secs;
         mv[0] = trap(v, 1000, 1000, 1980, 2000);
         mv[1] = tri_m(v, 1980, 2200, 2420);
         mv[2] = trap(v, 2400, 2420, 2500, 2500);
         mi[0] = trap(c, 0, 0, 70, 100);
         mi[1] = trap(c, 70, 100, 200, 200);
         mt[0] = trap(secs, 0, 0, 40, 60);
         mt[1] = trap(secs, 50, 60, 120, 120);
         if (v <= 1980 || v >= 2420 || c <= 70) begin
            dist_run = 1'b1;
         end else begin
            dist_secs = '0;
            dist_run = 1'b0;
         end
         sw = 0;
         swz = 0;
         for (int r = 0; r < 12; r++) begin
            w = mv[rv[r]];
            if (mi[ri[r]] < w) w = mi[ri[r]];
            if (mt[rt[r]] < w) w = mt[rt[r]];
            sw += w;
            swz += longint'(w) * zt[r];
         end
         if (sw == 0) q = 32768;
         else begin
            swz = (swz << 16) / (sw * 10);
            q = swz > 65536 ? 65536 : 32'(swz);
         end
      end
      cat = classify(q);
      e.level = 18'(q);
      e.cat = cat;
      e.relay = !(cat inside {CAT_OVER, CAT_UNDER, CAT_STANDBY, CAT_DANGER});
      e.red = !e.relay;
      e.blue = cat inside {CAT_SWELL, CAT_SAG};
      e.secs = 7'(secs);
      verdict_q.push_back(e);
   endtask

   function automatic sample_t rand_sample();
      sample_t s;
      int k;
      k = $urandom_range(0, 99);
      s.kind = k < 60 ? REQ_EVAL : (k < 88 ? REQ_TICK : (k < 96 ? REQ_BUTTON : REQ_UNUSED));
      k = $urandom_range(0, 9);
      if (k < 6) s.volt = 16'($urandom_range(1900, 2500));
      else if (k < 7) s.volt = '0;
      else if (k < 8) s.volt = 16'($urandom_range(1000, 1900));
      else s.volt = 16'($urandom);
      k = $urandom_range(0, 9);
      s.curr = k < 8 ? 17'($urandom_range(0, 260)) : 17'($urandom);
      return s;
   endfunction

   initial begin
      forever #10 clock = ~clock;
   end

   // Fill the pending queue and walk the idle and stall phases
   initial begin
      sample_t s;
      int unsigned dv[] = '{0, 999, 1000, 1980, 2000, 2200, 2400, 2420, 2500, 2501, 65535, 1};
      int unsigned di[] = '{0, 70, 100, 200, 131071, 85};
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      foreach (dv[i]) begin
         s.kind = REQ_EVAL; s.volt = 16'(dv[i]); s.curr = 17'(di[i % 6]);
         pending_q.push_back(s);
      end
      // grow the counter past both time-set breakpoints
      repeat (70) begin
         s.kind = REQ_TICK; s.volt = 16'hFFFF; s.curr = 17'h1FFFF;
         pending_q.push_back(s);
      end
      s.kind = REQ_EVAL; s.volt = 16'd1500; s.curr = 17'd150; pending_q.push_back(s);
      s.kind = REQ_BUTTON; pending_q.push_back(s);
      s.kind = REQ_UNUSED; pending_q.push_back(s);
      s.kind = REQ_EVAL; s.volt = 16'd2420; s.curr = 17'd40; pending_q.push_back(s);
      total = pending_q.size();
      for (int ph = 0; ph < 5; ph++) begin
         unique case (ph)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 75; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 75; end
            3: begin idle_pct = 29; stall_pct = 29; end
            default: begin idle_pct = 0; stall_pct = 0; end
         endcase
         repeat (100) pending_q.push_back(rand_sample());
         total += 100;
         wait (sent == total);
      end
      wait (verdict_q.size() == 0);
      repeat (100) @(posedge clock);
      if (fails == 0) begin
         $display("fuzzy_mains_quality_classifier_top: match");
      end else begin
         $display("fuzzy_mains_quality_classifier_top: mismatch");
      end
      $finish;
   end

   // Driver: predict on each transfer, then present the next item or idle
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            predict_sample(pending_q.pop_front());
            sent <= sent + 1;
         end
         if (!req_valid || !req_stall) begin
            if (pending_q.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
               req_valid <= 1'b1;
               req_type <= pending_q[0].kind;
               req_voltage_dv <= pending_q[0].volt;
               req_current_ma <= pending_q[0].curr;
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_stall <= $urandom_range(0, 99) < stall_pct;
      end
   end

   // Monitor: compare each result transfer with the oldest verdict
   always @(posedge clock) begin
      verdict_t e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (verdict_q.size() == 0) begin
            $error("unexpected result transfer");
            fails = fails + 1;
         end else begin
            e = verdict_q.pop_front();
            if (rsp_quality_level !== e.level) begin
               $error("quality_level exp %0d got %0d", e.level, rsp_quality_level);
               fails = fails + 1;
            end
            if (rsp_category !== e.cat) begin
               $error("category exp %0d got %0d", e.cat, rsp_category);
               fails = fails + 1;
            end
            if (rsp_relay_closed !== e.relay) begin
               $error("relay_closed exp %0d got %0d", e.relay, rsp_relay_closed);
               fails = fails + 1;
            end
            if (rsp_red_led !== e.red) begin
               $error("red_led exp %0d got %0d", e.red, rsp_red_led);
               fails = fails + 1;
            end
            if (rsp_blue_led !== e.blue) begin
               $error("blue_led exp %0d got %0d", e.blue, rsp_blue_led);
               fails = fails + 1;
            end
            if (rsp_override_hit !== e.ovr) begin
               $error("override_hit exp %0d got %0d", e.ovr, rsp_override_hit);
               fails = fails + 1;
            end
            if (rsp_seconds_used !== e.secs) begin
               $error("seconds_used exp %0d got %0d", e.secs, rsp_seconds_used);
               fails = fails + 1;
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      if (cycles >= CycleLimit) begin
         $display("fuzzy_mains_quality_classifier_top: mismatch");
         $finish;
      end
   end

endmodule

// ===== sim.f =====
hdl/fmqc_pkg.sv
hdl/fmqc_front.sv
hdl/fmqc_queue.sv
hdl/fmqc_back.sv
hdl/fuzzy_mains_quality_classifier_top.sv
tb/sv/tb_top.sv
